[design/rpa_pkg.sv]
package rpa_pkg;

	// Sizing of the page pool and the count memory.
	localparam int NUM_PAGES  = 32768;
	localparam int COUNT_BITS = 8;
	localparam int PAGE_W     = 15;
	localparam int IDX_W      = $clog2(NUM_PAGES);
	localparam int TOP_W      = $clog2(NUM_PAGES + 1);
	localparam int OUT_CNT_W  = 8;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [1:0] {
		ACT_FREE   = 2'd0,
		ACT_ALLOC  = 2'd1,
		ACT_ADDREF = 2'd2,
		ACT_COW    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK  = 2'd0,
		STAT_OOM = 2'd1,
		STAT_BAD = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_RD    = 5'b00100,
		ST_EXEC  = 5'b01000,
		ST_COW2  = 5'b10000
	} state_t;

	// Result word, listed from the highest bit down.
	typedef struct packed {
		logic [OUT_DATA_W-PAGE_W-OUT_CNT_W-4-1:0] pad;
		logic [OUT_CNT_W-1:0]                   ref_count;
		logic                                   must_copy;
		logic                                   page_valid;
		logic [PAGE_W-1:0]                      result_page;
		status_t                                status;
	} res_word_t;

	// Clamp a stored count to the width of the reported count.
	function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [COUNT_BITS-1:0] c);
		logic [OUT_CNT_W-1:0] r;
		if (32'(c) > ((32'd1 << OUT_CNT_W) - 32'd1))
			r = '1;
		else
			r = OUT_CNT_W'(c);
		return r;
	endfunction

endpackage

[design/refcounted_page_allocator_unit.sv]
// Reference-counted page allocator with a LIFO free stack.
//
// Requests arrive on the slave stream: s_tuser carries the action (free,
// allocate, add reference, copy-on-write) and s_tdata the page number. Each
// request yields exactly one result word on the master stream with status,
// result page, page-valid and must-copy flags and the updated count.
// The single configuration register (first usable page) is written through
// cfg_we/cfg_wdata and should only change while the block is idle.
//
// A request has a read step, which reads the count and stack memories, whose
// read data is registered, and a modify step, which modifies, writes back and
// loads the result register. A copy-on-write that hands out a fresh page adds
// a second count write step, as the count memory has one write port and both
// the old and the new page's counts change. m_tvalid rises at the end of the modify cycle.
//
// After reset the free stack is empty and every count is cleared by a pass
// over the count memory, one entry a cycle, all 32768 entries; s_tready
// stays low during that pass. When the receiver stalls, the result waits in
// the output register; the next request is still taken and read, and then
// holds in its modify cycle until the output register frees up.
module refcounted_page_allocator_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [rpa_pkg::IN_DATA_W-1:0]    s_tdata,   // [14:0] page
	input  logic [1:0]                       s_tuser,   // [1:0] action
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [rpa_pkg::OUT_DATA_W-1:0]   m_tdata,   // [1:0] status, [16:2] result_page,
	                                                    // [17] page_valid, [18] must_copy,
	                                                    // [26:19] ref_count
	input  logic                             cfg_we,
	input  logic [rpa_pkg::PAGE_W-1:0]       cfg_wdata
);

	localparam int IDX_W = rpa_pkg::IDX_W;
	localparam int TOP_W = rpa_pkg::TOP_W;
	localparam int CW    = rpa_pkg::COUNT_BITS;
	localparam int PW    = rpa_pkg::PAGE_W;

	rpa_pkg::state_t    state_q, state_d;
	rpa_pkg::action_t   act_q;
	logic [PW-1:0]      page_q;
	logic [PW-1:0]      first_q;
	logic [PW-1:0]      np_q;
	logic [TOP_W-1:0]   top_q;
	logic [IDX_W-1:0]   clr_q;
	logic               m_tvalid_q;
	rpa_pkg::res_word_t res_q;

	// Memory ports.
	logic               ref_we;
	logic [IDX_W-1:0]   ref_wa;
	logic [CW-1:0]      ref_wd;
	logic [CW-1:0]      ref_rd;
	logic               stk_we;
	logic [PW-1:0]      stk_rd;

	// Modify-cycle results before gating with the state.
	rpa_pkg::res_word_t res_d;
	logic               x_ref_we;
	logic [IDX_W-1:0]   x_ref_wa;
	logic [CW-1:0]      x_ref_wd;
	logic               x_stk_we;
	logic [TOP_W-1:0]   top_d;
	logic               need_cow2;

	logic               accept;
	logic               out_free;
	logic               exec_fire;
	logic               stk_empty;
	logic               stk_full;
	logic               in_range;
	logic [CW-1:0]      c_dec;

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign exec_fire = (state_q == rpa_pkg::ST_EXEC) && out_free;
	assign stk_empty = (top_q == '0);
	assign stk_full  = (top_q == TOP_W'(rpa_pkg::NUM_PAGES));
	assign in_range  = (32'(page_q) < rpa_pkg::NUM_PAGES);
	assign c_dec     = ref_rd - CW'(1);

	// A new request may enter from idle, from a modify cycle that completes
	// without a second count write, or from the second count write itself.
	assign s_tready = (state_q == rpa_pkg::ST_IDLE) ||
	                  (exec_fire && !need_cow2) ||
	                  (state_q == rpa_pkg::ST_COW2);

	rpa_ram #(.WIDTH(CW), .DEPTH(rpa_pkg::NUM_PAGES)) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.waddr (ref_wa),
		.wdata (ref_wd),
		.raddr (IDX_W'(page_q)),
		.rdata (ref_rd)
	);

	rpa_ram #(.WIDTH(PW), .DEPTH(rpa_pkg::NUM_PAGES)) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (IDX_W'(top_q)),
		.wdata (page_q),
		.raddr (IDX_W'(top_q - TOP_W'(1))),
		.rdata (stk_rd)
	);

	// Modify step: the count of the addressed page and the stack top are
	// valid here, in the cycle after the read addresses were presented.
	always_comb begin
		res_d     = '0;
		x_ref_we  = 1'b0;
		x_ref_wa  = IDX_W'(page_q);
		x_ref_wd  = '0;
		x_stk_we  = 1'b0;
		top_d     = top_q;
		need_cow2 = 1'b0;
		case (act_q)
			rpa_pkg::ACT_ALLOC: begin
				if (stk_empty) begin
					res_d.status = rpa_pkg::STAT_OOM;
				end else begin
					top_d             = top_q - TOP_W'(1);
					x_ref_we          = 1'b1;
					x_ref_wa          = IDX_W'(stk_rd);
					x_ref_wd          = CW'(1);
					res_d.result_page = stk_rd;
					res_d.page_valid  = 1'b1;
					res_d.ref_count   = rpa_pkg::OUT_CNT_W'(1);
				end
			end
			rpa_pkg::ACT_FREE: begin
				if (!in_range || (page_q < first_q)) begin
					res_d.status = rpa_pkg::STAT_BAD;
				end else if (ref_rd > CW'(1)) begin
					x_ref_we        = 1'b1;
					x_ref_wd        = c_dec;
					res_d.ref_count = rpa_pkg::sat_count(c_dec);
				end else if (stk_full) begin
					res_d.status    = rpa_pkg::STAT_BAD;
					res_d.ref_count = rpa_pkg::sat_count(ref_rd);
				end else begin
					x_ref_we = 1'b1;
					x_stk_we = 1'b1;
					top_d    = top_q + TOP_W'(1);
				end
			end
			rpa_pkg::ACT_ADDREF: begin
				if (!in_range) begin
					res_d.status = rpa_pkg::STAT_BAD;
				end else begin
					x_ref_we = 1'b1;
					x_ref_wd = (ref_rd == '1) ? ref_rd : ref_rd + CW'(1);
					res_d.ref_count = rpa_pkg::sat_count(x_ref_wd);
				end
			end
			rpa_pkg::ACT_COW: begin
				if (!in_range) begin
					res_d.status = rpa_pkg::STAT_BAD;
				end else if (ref_rd <= CW'(1)) begin
					res_d.result_page = page_q;
					res_d.page_valid  = 1'b1;
					res_d.ref_count   = rpa_pkg::sat_count(ref_rd);
				end else if (stk_empty) begin
					res_d.status    = rpa_pkg::STAT_OOM;
					res_d.ref_count = rpa_pkg::sat_count(ref_rd);
				end else begin
					top_d             = top_q - TOP_W'(1);
					x_ref_we          = 1'b1;
					res_d.result_page = stk_rd;
					res_d.page_valid  = 1'b1;
					res_d.must_copy   = 1'b1;
					if (stk_rd == page_q) begin
						// The popped page is the shared page itself: set to one,
						// then decremented, so it ends at zero.
						x_ref_wd        = '0;
						res_d.ref_count = '0;
					end else begin
						x_ref_wd        = c_dec;
						res_d.ref_count = rpa_pkg::sat_count(c_dec);
						need_cow2       = 1'b1;
					end
				end
			end
			default: begin
				res_d.status = rpa_pkg::STAT_BAD;
			end
		endcase
	end

	// Count memory write port: clearing pass, modify step, or the new page's
	// count in the second count write step of a copy-on-write.
	always_comb begin
		ref_we = 1'b0;
		ref_wa = x_ref_wa;
		ref_wd = x_ref_wd;
		stk_we = 1'b0;
		case (state_q)
			rpa_pkg::ST_CLEAR: begin
				ref_we = 1'b1;
				ref_wa = clr_q;
				ref_wd = '0;
			end
			rpa_pkg::ST_EXEC: begin
				ref_we = x_ref_we && out_free;
				stk_we = x_stk_we && out_free;
			end
			rpa_pkg::ST_COW2: begin
				ref_we = 1'b1;
				ref_wa = IDX_W'(np_q);
				ref_wd = CW'(1);
			end
			default: begin
				ref_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rpa_pkg::ST_CLEAR: begin
				if (clr_q == IDX_W'(rpa_pkg::NUM_PAGES - 1))
					state_d = rpa_pkg::ST_IDLE;
			end
			rpa_pkg::ST_IDLE: begin
				if (s_tvalid)
					state_d = rpa_pkg::ST_RD;
			end
			rpa_pkg::ST_RD: begin
				state_d = rpa_pkg::ST_EXEC;
			end
			rpa_pkg::ST_EXEC: begin
				if (out_free) begin
					if (need_cow2)
						state_d = rpa_pkg::ST_COW2;
					else if (s_tvalid)
						state_d = rpa_pkg::ST_RD;
					else
						state_d = rpa_pkg::ST_IDLE;
				end
			end
			rpa_pkg::ST_COW2: begin
				state_d = s_tvalid ? rpa_pkg::ST_RD : rpa_pkg::ST_IDLE;
			end
			default: begin
				state_d = rpa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rpa_pkg::ST_CLEAR;
			clr_q      <= '0;
			top_q      <= '0;
			first_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rpa_pkg::ST_CLEAR)
				clr_q <= clr_q + IDX_W'(1);
			if (cfg_we)
				first_q <= cfg_wdata;
			if (exec_fire)
				top_q <= top_d;
			if (exec_fire)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= rpa_pkg::action_t'(s_tuser);
			page_q <= s_tdata[PW-1:0];
		end
		if (exec_fire) begin
			res_q <= res_d;
			np_q  <= stk_rd;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = res_q;

`ifndef ASSERT_OFF
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(top_q) <= rpa_pkg::NUM_PAGES)
		else $error("free stack count beyond pool size");

	a_top_only_exec: assert property (@(posedge clk) disable iff (!arst_n)
		!exec_fire |=> (top_q == $past(top_q)))
		else $error("stack top moved outside a modify cycle");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rpa_pkg::ST_EXEC && m_tvalid_q && !m_tready) |=>
		(state_q == rpa_pkg::ST_EXEC))
		else $error("modify step left while result register was full");

	a_ref_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ref_we |-> (state_q != rpa_pkg::ST_IDLE && state_q != rpa_pkg::ST_RD))
		else $error("count memory written outside a write cycle");
`endif

endmodule

[design/rpa_ram.sv]
module rpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
